// ----- rtl/bce_pkg.sv -----
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types, constants and discharge curves for the charge estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

  localparam int MAX_CURVE_POINTS = 14;
  localparam int CURVE_SLOTS      = 16;
  localparam int DIV_STEPS        = 7;

  localparam logic [1:0] CFG_CHEMISTRY    = 2'd0;
  localparam logic [1:0] CFG_INVERT       = 2'd1;
  localparam logic [1:0] CFG_BALANCE_BAND = 2'd2;

  localparam logic [2:0] PS_CHARGING = 3'd0;
  localparam logic [2:0] PS_BALANCE  = 3'd1;
  localparam logic [2:0] PS_BATTERY  = 3'd2;
  localparam logic [2:0] PS_FULL     = 3'd3;
  localparam logic [2:0] PS_UNKNOWN  = 3'd4;

  localparam logic [14:0] FULL_MV_LIION = 15'd4150;
  localparam logic [14:0] FULL_MV_LFP   = 15'd3550;
  localparam logic [14:0] BAND_RESET    = 15'd100;

  localparam logic [12:0] LIION_MV [CURVE_SLOTS] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3750, 13'd3700, 13'd3650,
    13'd3600, 13'd3500, 13'd3400, 13'd3300, 13'd3000, 13'd0, 13'd0, 13'd0};
  localparam logic [6:0] LIION_PCT [CURVE_SLOTS] = '{
    7'd100, 7'd95, 7'd85, 7'd75, 7'd60, 7'd50, 7'd40, 7'd30,
    7'd20, 7'd10, 7'd5, 7'd2, 7'd0, 7'd0, 7'd0, 7'd0};
  localparam logic [12:0] LFP_MV [CURVE_SLOTS] = '{
    13'd3650, 13'd3400, 13'd3350, 13'd3320, 13'd3300, 13'd3280, 13'd3260, 13'd3240,
    13'd3220, 13'd3200, 13'd3150, 13'd3000, 13'd2800, 13'd2500, 13'd0, 13'd0};
  localparam logic [6:0] LFP_PCT [CURVE_SLOTS] = '{
    7'd100, 7'd95, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
    7'd30, 7'd20, 7'd10, 7'd5, 7'd2, 7'd0, 7'd0, 7'd0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH,
    ST_DONE
  } bce_state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic mul;
    logic div_init;
    logic div_step;
    logic finish;
    logic publish;
  } bce_cmd_t;

  typedef struct packed {
    logic early;
    logic seg_hit;
  } bce_sts_t;

  function automatic logic [12:0] curve_mv(logic chem, logic [3:0] idx);
    return chem ? LFP_MV[idx] : LIION_MV[idx];
  endfunction

  function automatic logic [6:0] curve_pct(logic chem, logic [3:0] idx);
    return chem ? LFP_PCT[idx] : LIION_PCT[idx];
  endfunction

  function automatic logic [3:0] curve_last(logic chem);
    int len;
    len = chem ? 14 : 13;
    if (len > MAX_CURVE_POINTS) len = MAX_CURVE_POINTS;
    if (len < 2) len = 2;
    if (len > CURVE_SLOTS) len = CURVE_SLOTS;
    return 4'(len - 1);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/battery_charge_estimator_core.sv -----
// ----------------------------------------------------------------------------
// battery_charge_estimator_core
// State of charge, current and power state from one voltage/current sample.
// ----------------------------------------------------------------------------
// Input beat: raise start with the in_* fields; the beat is taken at an edge
// where start is high and busy is low. busy stays high until the result goes
// out. Result beat: out_valid is high for exactly one cycle with the out_*
// fields; the receiver cannot stall, so it must take it then.
// Flow: a failed read, or a voltage on or beyond a curve end, goes from the
// endpoint check straight to publish; otherwise the curve segments (1 to 13
// of them) are scanned, one per cycle, up to and including the matching one,
// and then come the multiply, the 7-step restoring divider for the rounded
// quotient, the final sum and the publish. A new item may be started in the
// cycle out_valid shows.
// Configuration: cfg_we, cfg_index, cfg_wdata; write only while busy is low.
// Reset (synchronous, rst_n low) returns the sequencer to idle, drops
// out_valid and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_estimator_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [15:0]        in_bus_raw,
  input  wire logic signed [15:0] in_current_raw,
  input  wire logic               in_voltage_read_ok,
  input  wire logic               in_current_read_ok,
  output logic                    out_valid,
  output logic [14:0]             out_bus_mv,
  output logic signed [15:0]      out_current_tenth_ma,
  output logic [6:0]              out_charge_percent,
  output logic [2:0]              out_power_state,
  output logic                    out_reading_valid,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_wdata
);

  bce_pkg::bce_cmd_t cmd;
  bce_pkg::bce_sts_t sts;

  bce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bce_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_bus_raw           (in_bus_raw),
    .in_current_raw       (in_current_raw),
    .in_voltage_read_ok   (in_voltage_read_ok),
    .in_current_read_ok   (in_current_read_ok),
    .out_valid            (out_valid),
    .out_bus_mv           (out_bus_mv),
    .out_current_tenth_ma (out_current_tenth_ma),
    .out_charge_percent   (out_charge_percent),
    .out_power_state      (out_power_state),
    .out_reading_valid    (out_reading_valid)
  );

endmodule

`default_nettype wire

// ----- rtl/bce_ctrl.sv -----
// ----------------------------------------------------------------------------
// bce_ctrl
// Sequencer: endpoint check, segment scan, multiply, serial divide, publish.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire bce_pkg::bce_sts_t sts,
  output bce_pkg::bce_cmd_t      cmd,
  output logic                   busy
);

  bce_pkg::bce_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bce_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    busy      = (state_r != bce_pkg::ST_IDLE);
    case (state_r)
      bce_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = bce_pkg::ST_CHECK;
        end
      end
      bce_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.early ? bce_pkg::ST_DONE : bce_pkg::ST_SCAN;
      end
      bce_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.seg_hit) state_nxt = bce_pkg::ST_MUL;
      end
      bce_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = bce_pkg::ST_DIV_INIT;
      end
      bce_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = bce_pkg::ST_DIV;
      end
      bce_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 3'd1;
        if (cnt_r == 3'(bce_pkg::DIV_STEPS - 1)) state_nxt = bce_pkg::ST_FINISH;
      end
      bce_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = bce_pkg::ST_DONE;
      end
      bce_pkg::ST_DONE: begin
        cmd.publish = 1'b1;
        state_nxt   = bce_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bce_datapath.sv -----
// ----------------------------------------------------------------------------
// bce_datapath
// Config registers, sample scaling, curve interpolation and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bce_pkg::bce_cmd_t  cmd,
  output bce_pkg::bce_sts_t       sts,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_wdata,
  input  wire logic [15:0]        in_bus_raw,
  input  wire logic signed [15:0] in_current_raw,
  input  wire logic               in_voltage_read_ok,
  input  wire logic               in_current_read_ok,
  output logic                    out_valid,
  output logic [14:0]             out_bus_mv,
  output logic signed [15:0]      out_current_tenth_ma,
  output logic [6:0]              out_charge_percent,
  output logic [2:0]              out_power_state,
  output logic                    out_reading_valid
);

  logic        chem_r, inv_r;
  logic [14:0] band_r;

  logic [14:0]        mv_r;
  logic signed [15:0] cur_r;
  logic               ok_r;
  logic [2:0]         st_r;
  logic [6:0]         pct_r;
  logic [3:0]         idx_r;
  logic [10:0]        den_r, diff_r;
  logic [6:0]         pl_r, dp_r, q_r;
  logic [17:0]        prod_r, div_r;
  logic [18:0]        rem_r;
  logic               out_valid_r;

  logic [12:0]        top_mv, last_mv, hi_mv, lo_mv;
  logic [6:0]         hi_pct, lo_pct;
  logic [3:0]         idx_p1;
  logic signed [16:0] cur_x, band_x;
  logic [14:0]        full_mv;
  logic [7:0]         sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chem_r <= 1'b0;
      inv_r  <= 1'b0;
      band_r <= bce_pkg::BAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bce_pkg::CFG_CHEMISTRY:    chem_r <= cfg_wdata[0];
        bce_pkg::CFG_INVERT:       inv_r  <= cfg_wdata[0];
        bce_pkg::CFG_BALANCE_BAND: band_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign top_mv  = bce_pkg::curve_mv(chem_r, 4'd0);
  assign last_mv = bce_pkg::curve_mv(chem_r, bce_pkg::curve_last(chem_r));
  assign idx_p1  = idx_r + 4'd1;
  assign hi_mv   = bce_pkg::curve_mv(chem_r, idx_r);
  assign lo_mv   = bce_pkg::curve_mv(chem_r, idx_p1);
  assign hi_pct  = bce_pkg::curve_pct(chem_r, idx_r);
  assign lo_pct  = bce_pkg::curve_pct(chem_r, idx_p1);
  assign cur_x   = 17'(cur_r);
  assign band_x  = signed'({2'b00, band_r});
  assign full_mv = chem_r ? bce_pkg::FULL_MV_LFP : bce_pkg::FULL_MV_LIION;
  assign sum     = {1'b0, pl_r} + {1'b0, q_r};

  assign sts.early   = !ok_r || (mv_r >= {2'b00, top_mv}) || (mv_r <= {2'b00, last_mv});
  assign sts.seg_hit = (mv_r >= {2'b00, lo_mv});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mv_r <= {in_bus_raw[15:3], 2'b00};
      ok_r <= in_voltage_read_ok && in_current_read_ok;
      if (inv_r && (in_current_raw == 16'sh8000)) cur_r <= 16'sh7FFF;
      else if (inv_r) cur_r <= -in_current_raw;
      else cur_r <= in_current_raw;
    end
    if (cmd.check) begin
      idx_r <= '0;
      pct_r <= (mv_r >= {2'b00, top_mv}) ? 7'd100 : 7'd0;
      if (cur_x >= band_x) st_r <= bce_pkg::PS_CHARGING;
      else if (cur_x <= -band_x) st_r <= bce_pkg::PS_BATTERY;
      else if (mv_r >= full_mv) st_r <= bce_pkg::PS_FULL;
      else st_r <= bce_pkg::PS_BALANCE;
    end
    if (cmd.scan) begin
      if (sts.seg_hit) begin
        den_r  <= 11'(hi_mv - lo_mv);
        diff_r <= 11'(mv_r - {2'b00, lo_mv});
        pl_r   <= lo_pct;
        dp_r   <= (hi_pct >= lo_pct) ? (hi_pct - lo_pct) : 7'd0;
      end else begin
        idx_r  <= idx_p1;
      end
    end
    if (cmd.mul) prod_r <= {7'd0, diff_r} * {11'd0, dp_r};
    if (cmd.div_init) begin
      rem_r <= {prod_r, 1'b0} + {8'd0, den_r};
      div_r <= {den_r, 1'b0, 6'd0};
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if ({1'b0, div_r} <= rem_r) begin
        rem_r <= rem_r - {1'b0, div_r};
        q_r   <= {q_r[5:0], 1'b1};
      end else begin
        q_r   <= {q_r[5:0], 1'b0};
      end
      div_r <= {1'b0, div_r[17:1]};
    end
    if (cmd.finish) pct_r <= (sum > 8'd100) ? 7'd100 : sum[6:0];
    if (cmd.publish) begin
      out_reading_valid <= ok_r;
      if (ok_r) begin
        out_bus_mv           <= mv_r;
        out_current_tenth_ma <= cur_r;
        out_charge_percent   <= pct_r;
        out_power_state      <= st_r;
      end else begin
        out_bus_mv           <= '0;
        out_current_tenth_ma <= '0;
        out_charge_percent   <= '0;
        out_power_state      <= bce_pkg::PS_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.publish;
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/bce_checker.sv -----
// ----------------------------------------------------------------------------
// bce_checker
// Port-level checks on the charge estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [14:0]        out_bus_mv,
  input wire logic signed [15:0] out_current_tenth_ma,
  input wire logic [6:0]         out_charge_percent,
  input wire logic [2:0]         out_power_state,
  input wire logic               out_reading_valid
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_charge_percent <= 7'd100))
    else $error("charge percent out of range");

  a_invalid_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reading_valid) |->
      (out_power_state == bce_pkg::PS_UNKNOWN && out_charge_percent == 7'd0 &&
       out_bus_mv == 15'd0 && out_current_tenth_ma == 16'sd0))
    else $error("failed read beat carries data");

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reading_valid) |-> (out_power_state != bce_pkg::PS_UNKNOWN))
    else $error("good read beat reports unknown power state");

endmodule

bind battery_charge_estimator_core bce_checker u_bce_checker (.*);

`default_nettype wire
